[design/atmf_pkg.sv]
// atmf_pkg: sizes, types and sequencer codes of the trimmed mean filter
// no dependencies; used by every module of the block by scoped names

package atmf_pkg;

    // block configuration
    localparam int CHANNELS    = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int KEPT        = 4;
    localparam int WIN         = KEPT + 1;

    // fixed port widths
    localparam int CH_W   = 3;
    localparam int SMP_W  = 12;
    localparam int FILT_W = 12;

    // derived widths
    localparam int ROW_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W  = $clog2(WIN);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WIN);

    // divide by three as multiply by ceil(2^k / 3), exact for sum < 2^(k-1)
    localparam int DIV3_SHIFT = SUM_W + 1;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int PROD_W     = SUM_W + DIV3_SHIFT;

    typedef logic [SAMPLE_BITS-1:0]            t_smp;
    typedef logic [KEPT-1:0][SAMPLE_BITS-1:0]  t_row;
    typedef logic [ROW_W-1:0]                  t_rowidx;
    typedef logic [IDX_W-1:0]                  t_idx;
    typedef logic [CNT_W-1:0]                  t_cnt;
    typedef logic [SUM_W-1:0]                  t_sum;
    typedef logic [PROD_W-1:0]                 t_prod;
    typedef logic [CH_W-1:0]                   t_chan;
    typedef logic [SMP_W-1:0]                  t_port_smp;
    typedef logic [FILT_W-1:0]                 t_filt;

    // running state of the shared scan unit
    typedef struct packed {
        t_smp hi;
        t_smp lo;
        t_sum sum;
        t_cnt cnt;
    } t_acc;

    typedef enum logic {
        OP_EXTREMES,
        OP_ACCUM
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXTREMES,
        S_ACCUM,
        S_DIVIDE
    } t_state;

endpackage

[design/atmf_store.sv]
// atmf_store: per-channel rows of the four most recent samples, cleared by reset
// depends on atmf_pkg

module atmf_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atmf_pkg::t_rowidx i_row,
    input  logic              i_wr,
    input  atmf_pkg::t_row    i_wdata,
    output atmf_pkg::t_row    o_rdata
);

    atmf_pkg::t_row r_rows [atmf_pkg::CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < atmf_pkg::CHANNELS; c++) begin
                r_rows[c] <= '0;
            end
        end else if (i_wr) begin
            r_rows[i_row] <= i_wdata;
        end
    end

    assign o_rdata = r_rows[i_row];

endmodule

[design/atmf_unit.sv]
// atmf_unit: shared compare and accumulate step, one window sample per use
// depends on atmf_pkg

module atmf_unit (
    input  atmf_pkg::t_op  i_op,
    input  atmf_pkg::t_smp i_elem,
    input  atmf_pkg::t_acc i_acc,
    output atmf_pkg::t_acc o_acc
);

    always_comb begin
        o_acc = i_acc;
        unique case (i_op)
            atmf_pkg::OP_EXTREMES: begin
                if (i_elem > i_acc.hi) begin
                    o_acc.hi = i_elem;
                end
                if (i_elem < i_acc.lo) begin
                    o_acc.lo = i_elem;
                end
            end
            atmf_pkg::OP_ACCUM: begin
                // every copy of an extreme is left out
                if ((i_elem > i_acc.lo) && (i_elem < i_acc.hi)) begin
                    o_acc.sum = i_acc.sum + atmf_pkg::t_sum'(i_elem);
                    o_acc.cnt = i_acc.cnt + atmf_pkg::t_cnt'(1);
                end
            end
            default: begin
                o_acc = i_acc;
            end
        endcase
    end

endmodule

[design/adc_trimmed_mean_filter.sv]
// adc_trimmed_mean_filter: five-sample trimmed mean filter for converter channels
// depends on atmf_pkg, atmf_store and atmf_unit
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_channel, i_sample
//  result    out        o_valid / i_stall    o_filtered, o_channel_ok
//
// a valid channel goes from transfer to result through one load, WIN passes of the
// shared unit for max and min, WIN passes for the sum, one divide and load of the result
// an invalid channel skips the load and the scan passes and goes straight to the divide
// the next input is taken the cycle after the result register is loaded
// reset clears the sequencer, the result valid and every window row to zeros
// a stalled result holds; the divide step waits until the result register is free

module adc_trimmed_mean_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  atmf_pkg::t_chan      i_channel,
    input  atmf_pkg::t_port_smp  i_sample,
    output logic                 o_valid,
    input  logic                 i_stall,
    output atmf_pkg::t_filt      o_filtered,
    output logic                 o_channel_ok
);

    // sequencer and working registers
    atmf_pkg::t_state r_state, n_state;
    atmf_pkg::t_idx   r_k, n_k;
    atmf_pkg::t_smp   r_win [atmf_pkg::WIN];
    atmf_pkg::t_smp   n_win [atmf_pkg::WIN];
    atmf_pkg::t_acc   r_acc, n_acc;
    logic             r_ok, n_ok;

    // result register
    logic             r_out_valid, n_out_valid;
    atmf_pkg::t_filt  r_out_filt, n_out_filt;
    logic             r_out_ok, n_out_ok;

    // store and unit connections
    atmf_pkg::t_rowidx row_idx;
    atmf_pkg::t_row    row_rd;
    atmf_pkg::t_row    row_wr;
    logic              row_we;
    atmf_pkg::t_op     unit_op;
    atmf_pkg::t_acc    unit_out;

    atmf_pkg::t_smp    new_smp;
    logic              chan_valid;
    logic              out_free;
    atmf_pkg::t_prod   prod3;
    atmf_pkg::t_sum    quot;

    assign new_smp    = atmf_pkg::t_smp'(i_sample);
    assign chan_valid = (i_channel != atmf_pkg::t_chan'(0))
                        && (int'(i_channel) <= atmf_pkg::CHANNELS);
    assign row_idx    = atmf_pkg::t_rowidx'(i_channel - atmf_pkg::t_chan'(1));
    assign out_free   = !r_out_valid || !i_stall;

    // new row: drop the oldest, append the new sample
    always_comb begin
        for (int k = 0; k < atmf_pkg::KEPT - 1; k++) begin
            row_wr[k] = row_rd[k+1];
        end
        row_wr[atmf_pkg::KEPT-1] = new_smp;
    end

    atmf_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_idx),
        .i_wr    (row_we),
        .i_wdata (row_wr),
        .o_rdata (row_rd)
    );

    atmf_unit u_unit (
        .i_op   (unit_op),
        .i_elem (r_win[r_k]),
        .i_acc  (r_acc),
        .o_acc  (unit_out)
    );

    // divide by the count, which never exceeds three
    assign prod3 = atmf_pkg::t_prod'(r_acc.sum) * atmf_pkg::t_prod'(atmf_pkg::DIV3_MUL);

    always_comb begin
        unique case (r_acc.cnt)
            atmf_pkg::t_cnt'(1): quot = r_acc.sum;
            atmf_pkg::t_cnt'(2): quot = r_acc.sum >> 1;
            atmf_pkg::t_cnt'(3): quot = atmf_pkg::t_sum'(prod3 >> atmf_pkg::DIV3_SHIFT);
            default:             quot = '0;
        endcase
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_win       = r_win;
        n_acc       = r_acc;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_filt  = r_out_filt;
        n_out_ok    = r_out_ok;
        row_we      = 1'b0;
        unit_op     = atmf_pkg::OP_EXTREMES;
        o_stall     = 1'b1;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            atmf_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_k     = '0;
                    n_acc   = '{hi: '0, lo: '1, sum: '0, cnt: '0};
                    n_ok    = chan_valid;
                    if (chan_valid) begin
                        for (int k = 0; k < atmf_pkg::KEPT; k++) begin
                            n_win[k] = row_rd[k];
                        end
                        n_win[atmf_pkg::KEPT] = new_smp;
                        row_we  = 1'b1;
                        n_state = atmf_pkg::S_EXTREMES;
                    end else begin
                        n_state = atmf_pkg::S_DIVIDE;
                    end
                end
            end
            atmf_pkg::S_EXTREMES: begin
                unit_op = atmf_pkg::OP_EXTREMES;
                n_acc   = unit_out;
                if (r_k == atmf_pkg::t_idx'(atmf_pkg::WIN - 1)) begin
                    n_k     = '0;
                    n_state = atmf_pkg::S_ACCUM;
                end else begin
                    n_k = r_k + atmf_pkg::t_idx'(1);
                end
            end
            atmf_pkg::S_ACCUM: begin
                unit_op = atmf_pkg::OP_ACCUM;
                n_acc   = unit_out;
                if (r_k == atmf_pkg::t_idx'(atmf_pkg::WIN - 1)) begin
                    n_k     = '0;
                    n_state = atmf_pkg::S_DIVIDE;
                end else begin
                    n_k = r_k + atmf_pkg::t_idx'(1);
                end
            end
            atmf_pkg::S_DIVIDE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_filt  = r_ok ? atmf_pkg::t_filt'(quot) : '0;
                    n_out_ok    = r_ok;
                    n_state     = atmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = atmf_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atmf_pkg::S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_acc      <= n_acc;
        r_ok       <= n_ok;
        r_out_filt <= n_out_filt;
        r_out_ok   <= n_out_ok;
    end

    assign o_valid      = r_out_valid;
    assign o_filtered   = r_out_filt;
    assign o_channel_ok = r_out_ok;

endmodule

[design/atmf_checker.sv]
// atmf_checker: port-level checks of the trimmed mean filter, bound to the top level
// depends on atmf_pkg and adc_trimmed_mean_filter

module atmf_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             o_stall,
    input  logic             o_valid,
    input  logic             i_stall,
    input  atmf_pkg::t_filt  o_filtered,
    input  logic             o_channel_ok
);

    // nothing is pending straight after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a rejected channel always reports zero
    a_bad_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_channel_ok) |-> (o_filtered == '0))
        else $error("nonzero result for invalid channel");

    // one item at a time: a transfer makes the block busy
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while busy");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_filtered) && $stable(o_channel_ok)))
        else $error("stalled result changed");

endmodule

bind adc_trimmed_mean_filter atmf_checker u_atmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_filtered   (o_filtered),
    .o_channel_ok (o_channel_ok)
);

[test/atmf_checker.sv]
// atmf_scoreboard: watches both channels of the trimmed mean filter, predicts and checks results
// depends on atmf_pkg; keeps its own per-channel sample history

module atmf_scoreboard (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  atmf_pkg::t_chan     i_channel,
    input  atmf_pkg::t_port_smp i_sample,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  atmf_pkg::t_filt     i_filtered,
    input  logic                i_channel_ok,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef logic [atmf_pkg::WIN-1:0][atmf_pkg::SAMPLE_BITS-1:0] t_window;

    typedef struct packed {
        atmf_pkg::t_filt filtered;
        logic            channel_ok;
    } t_filter_out;

    atmf_pkg::t_row chan_history [atmf_pkg::CHANNELS];
    t_filter_out    filter_outs_due [$];
    int             mismatches = 0;

    // mean of the samples strictly between the window's extremes
    function automatic atmf_pkg::t_filt olympic_mean(input t_window win);
        atmf_pkg::t_smp hi;
        atmf_pkg::t_smp lo;
        int             sum;
        int             cnt;
        hi  = win[0];
        lo  = win[0];
        sum = 0;
        cnt = 0;
        for (int k = 1; k < atmf_pkg::WIN; k++) begin
            if (win[k] > hi) hi = win[k];
            if (win[k] < lo) lo = win[k];
        end
        for (int k = 0; k < atmf_pkg::WIN; k++) begin
            if (win[k] > lo && win[k] < hi) begin
                sum += int'(win[k]);
                cnt++;
            end
        end
        return (cnt > 0) ? atmf_pkg::t_filt'(sum / cnt) : '0;
    endfunction

    task automatic flag_field(input string field, input int want, input int got);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_filter_out due;
        t_window     win;
        int          row;
        if (!i_rst_n) begin
            foreach (chan_history[r]) chan_history[r] = '0;
            filter_outs_due.delete();
        end else begin
            // result side first: it always belongs to an earlier transfer
            if (i_out_valid && !i_out_stall) begin
                if (filter_outs_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none actual filtered %0d channel_ok %0b",
                             $time, i_filtered, i_channel_ok);
                end else begin
                    due = filter_outs_due.pop_front();
                    if (i_filtered !== due.filtered)
                        flag_field("filtered", int'(due.filtered), int'(i_filtered));
                    if (i_channel_ok !== due.channel_ok)
                        flag_field("channel_ok", int'(due.channel_ok), int'(i_channel_ok));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_channel >= 1 && i_channel <= atmf_pkg::CHANNELS) begin
                    row = int'(i_channel) - 1;
                    win = {atmf_pkg::t_smp'(i_sample), chan_history[row]};
                    chan_history[row] = win[atmf_pkg::WIN-1:1];
                    filter_outs_due.push_back('{filtered: olympic_mean(win), channel_ok: 1'b1});
                end else begin
                    filter_outs_due.push_back('{filtered: '0, channel_ok: 1'b0});
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= filter_outs_due.size();
    end

endmodule

[test/testbench.sv]
// testbench: drives the trimmed mean filter with directed and random samples under back-pressure
// depends on atmf_pkg, adc_trimmed_mean_filter and atmf_scoreboard

module testbench;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    atmf_pkg::t_chan     i_channel;
    atmf_pkg::t_port_smp i_sample;
    logic                o_valid;
    logic                i_stall;
    atmf_pkg::t_filt     o_filtered;
    logic                o_channel_ok;

    int fail_count;
    int results_owed;

    // idle rates in percent, changed per phase
    int   tx_idle_pct = 28;
    int   rx_idle_pct = 65;
    // asks the receiver for one long hold-off
    logic hold_req    = 1'b0;

    always #5 i_clk = ~i_clk;

    adc_trimmed_mean_filter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered   (o_filtered),
        .o_channel_ok (o_channel_ok)
    );

    atmf_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_filtered   (o_filtered),
        .i_channel_ok (o_channel_ok),
        .o_fail_count (fail_count),
        .o_pending    (results_owed)
    );

    // offer one sample, with random idle cycles first; returns on the edge of the transfer
    task automatic offer_reading(input atmf_pkg::t_chan ch, input atmf_pkg::t_port_smp smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_channel <= ch;
        i_sample  <= smp;
        // o_stall read here is the value the block saw at this edge
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up into its input
    initial begin
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 299;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        atmf_pkg::t_chan     ch;
        atmf_pkg::t_port_smp smp;
        atmf_pkg::t_port_smp level [8];

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_channel <= '0;
        i_sample  <= '0;
        foreach (level[c]) level[c] = atmf_pkg::t_port_smp'($urandom_range(4095 - 40));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        // fresh channel, window of zeros only: flat, so nothing qualifies
        offer_reading(atmf_pkg::t_chan'(1), '0);
        // channels out of range leave every window alone
        offer_reading(atmf_pkg::t_chan'(0), 12'hFFF);
        offer_reading(atmf_pkg::t_chan'(6), 12'hAAA);
        offer_reading(atmf_pkg::t_chan'(7), 12'h555);
        // full scale and near-extreme values mixed with zeros
        offer_reading(atmf_pkg::t_chan'(2), 12'hFFF);
        offer_reading(atmf_pkg::t_chan'(2), 12'h800);
        offer_reading(atmf_pkg::t_chan'(2), 12'h001);
        offer_reading(atmf_pkg::t_chan'(2), 12'hFFF);
        offer_reading(atmf_pkg::t_chan'(2), 12'h7FF);
        // constant input fills the window until it goes flat
        repeat (5) offer_reading(atmf_pkg::t_chan'(3), 12'd100);
        // only two distinct values in the window
        for (int k = 0; k < 5; k++)
            offer_reading(atmf_pkg::t_chan'(4), (k % 2) ? 12'hFFF : 12'h000);
        // descending run from the top of the range
        offer_reading(atmf_pkg::t_chan'(5), 12'hFFF);
        offer_reading(atmf_pkg::t_chan'(5), 12'hFFE);
        offer_reading(atmf_pkg::t_chan'(5), 12'hFFD);
        offer_reading(atmf_pkg::t_chan'(5), 12'h001);
        offer_reading(atmf_pkg::t_chan'(5), 12'h000);

        // random part in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 500; n++) begin
                // long hold-off while the sender keeps offering flat out
                if (phase == 2 && n == 40) hold_req <= 1'b1;
                if ($urandom_range(99) < 12) begin
                    case ($urandom_range(2))
                        0:       ch = atmf_pkg::t_chan'(0);
                        1:       ch = atmf_pkg::t_chan'(6);
                        default: ch = atmf_pkg::t_chan'(7);
                    endcase
                end else begin
                    ch = atmf_pkg::t_chan'($urandom_range(atmf_pkg::CHANNELS, 1));
                end
                // each channel wanders around a level of its own, now and then moving
                if ($urandom_range(31) == 0)
                    level[ch] = atmf_pkg::t_port_smp'($urandom_range(4095 - 40));
                case ($urandom_range(9))
                    0:       smp = $urandom_range(1) ? 12'hFFF : 12'h000;
                    1, 2:    smp = atmf_pkg::t_port_smp'($urandom);
                    default: smp = level[ch] +
                                   atmf_pkg::t_port_smp'($urandom_range(
                                       $urandom_range(1) ? 3 : 40));
                endcase
                offer_reading(ch, smp);
            end
        end
        i_valid <= 1'b0;

        // let the last transfer register, then drain and allow for the block's latency
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
